>>> hw/rtl/bfsk_pkg.sv
// ----------------------------------------------------------------------------
// bfsk_pkg
// Shared widths, register indexes and the quarter-wave sine builder for the
// binary FSK I/Q modulator.
// ----------------------------------------------------------------------------
package bfsk_pkg;

    localparam int STEP_W      = 32;
    localparam int PHASE_W     = 32;
    localparam int SPB_W       = 7;
    localparam int AMP_W       = 7;
    localparam int SAMPLE_W    = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 2 * SAMPLE_W;

    localparam logic [SPB_W-1:0] MAX_SAMPLES = 7'd64;

    localparam logic [CFG_ADDR_W-1:0] REG_MARK_STEP  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPACE_STEP = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPB        = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE  = 2'd3;

    localparam logic [STEP_W-1:0] MARK_STEP_RST  = 32'd103079215;
    localparam logic [STEP_W-1:0] SPACE_STEP_RST = 32'd17179869;
    localparam logic [SPB_W-1:0]  SPB_RST        = 7'd50;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST  = 7'd126;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Taylor term divisors (2n)(2n+1)
    function automatic logic [63:0] series_div(input logic [63:0] prod, input int n);
        logic [63:0] res;
        case (n)
            1:       res = prod / 64'd6;
            2:       res = prod / 64'd20;
            3:       res = prod / 64'd42;
            4:       res = prod / 64'd72;
            5:       res = prod / 64'd110;
            default: res = prod / 64'd156;
        endcase
        return res;
    endfunction

    // Magnitude of sin(r * (pi/2) / 2^(phase_bits-2)), frac_bits fraction bits
    function automatic logic [31:0] sine_mag(input int unsigned r,
                                             input int unsigned phase_bits,
                                             input int unsigned frac_bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        x    = (64'(r) * HALF_PI_Q30) >> (phase_bits - 2);
        sum  = longint'(x);
        term = x;
        for (int n = 1; n <= 6; n++)
        begin
            term = series_div((((term * x) >> 30) * x) >> 30, n);
            if ((n & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q30))
            sum = longint'(ONE_Q30);
        v = 64'(sum);
        v = (v + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
        return v[31:0];
    endfunction

endpackage

>>> hw/rtl/bfsk_sine_lut.sv
// ----------------------------------------------------------------------------
// bfsk_sine_lut
// Full-wave sine lookup built from a quarter-wave constant table; returns
// magnitude and sign for one phase index.
// ----------------------------------------------------------------------------
module bfsk_sine_lut #(
    parameter int TABLE_PHASE_BITS    = 10,
    parameter int TABLE_FRACTION_BITS = 15
) (
    input  logic [TABLE_PHASE_BITS-1:0]  idx,
    output logic [TABLE_FRACTION_BITS:0] mag,
    output logic                         neg
);

    localparam int QUARTER = 1 << (TABLE_PHASE_BITS - 2);
    localparam int MAG_W   = TABLE_FRACTION_BITS + 1;
    localparam int R_W     = TABLE_PHASE_BITS - 1;

    logic [MAG_W-1:0] qtab [0:QUARTER];
    logic [1:0]       quad;
    logic [R_W-1:0]   r_raw;
    logic [R_W-1:0]   r_fold;

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_tab
        assign qtab[g] = MAG_W'(bfsk_pkg::sine_mag(g, TABLE_PHASE_BITS, TABLE_FRACTION_BITS));
    end

    always_comb
    begin
        quad   = idx[TABLE_PHASE_BITS-1 -: 2];
        r_raw  = R_W'(idx[TABLE_PHASE_BITS-3:0]);
        r_fold = quad[0] ? (R_W'(QUARTER) - r_raw) : r_raw;
        mag    = qtab[r_fold];
        neg    = quad[1];
    end

endmodule

>>> hw/rtl/binary_fsk_iq_modulator.sv
// ----------------------------------------------------------------------------
// binary_fsk_iq_modulator
// Binary FSK modulator: one bit in, samples_per_bit I/Q samples out.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit first)
//  s_*       in   tdata: data_bit, zero pad / tuser: kind
//  m_*       out  tdata: i_sample, q_sample / tlast: last
//  cfg_*     in   cfg_addr: register index, cfg_wdata: value
//
//  A bit transaction produces samples_per_bit samples (1..64), one sample
//  per cycle unless m_tready stalls; an idle transaction gives one zero
//  sample. The next transaction is taken in the cycle the last sample leaves
//  the phase generator. Samples pass through index, table and scale stages.
//  A stalled m_tready freezes the whole pipeline. Reset clears the phases.
// ----------------------------------------------------------------------------
module binary_fsk_iq_modulator #(
    parameter int TABLE_PHASE_BITS    = 10,
    parameter int TABLE_FRACTION_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bfsk_pkg::IN_DATA_W-1:0]      s_tdata,   // data_bit, pad
    input  logic                                s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bfsk_pkg::OUT_DATA_W-1:0]     m_tdata,   // i_sample, q_sample
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [bfsk_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bfsk_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int P       = TABLE_PHASE_BITS;
    localparam int F       = TABLE_FRACTION_BITS;
    localparam int MAG_W   = F + 1;
    localparam int PROD_W  = bfsk_pkg::AMP_W + MAG_W;
    localparam int QUARTER = 1 << (P - 2);
    localparam int SW      = bfsk_pkg::SAMPLE_W;

    // configuration
    logic [bfsk_pkg::STEP_W-1:0] mark_step_reg;
    logic [bfsk_pkg::STEP_W-1:0] space_step_reg;
    logic [bfsk_pkg::SPB_W-1:0]  spb_reg;
    logic [bfsk_pkg::AMP_W-1:0]  amplitude_reg;

    // phase generator
    logic                         gen_active_reg, gen_active_next;
    logic                         gen_idle_reg, gen_idle_next;
    logic                         gen_mark_reg, gen_mark_next;
    logic [bfsk_pkg::SPB_W-1:0]   gen_left_reg, gen_left_next;
    logic [bfsk_pkg::PHASE_W-1:0] mark_phase_reg, mark_phase_next;
    logic [bfsk_pkg::PHASE_W-1:0] space_phase_reg, space_phase_next;
    logic [bfsk_pkg::PHASE_W-1:0] sel_phase;
    logic [bfsk_pkg::SPB_W-1:0]   count;
    logic                         pipe_en;
    logic                         gen_fire;
    logic                         gen_done;
    logic                         accept;

    // index stage
    logic         a_valid_reg;
    logic         a_zero_reg;
    logic         a_last_reg;
    logic [P-1:0] a_sin_idx_reg;
    logic [P-1:0] a_cos_idx_reg;

    // table stage
    logic             b_valid_reg;
    logic             b_zero_reg;
    logic             b_last_reg;
    logic [MAG_W-1:0] b_sin_mag_reg;
    logic             b_sin_neg_reg;
    logic [MAG_W-1:0] b_cos_mag_reg;
    logic             b_cos_neg_reg;
    logic [MAG_W-1:0] sin_mag;
    logic             sin_neg;
    logic [MAG_W-1:0] cos_mag;
    logic             cos_neg;

    // scale stage
    logic              out_valid_reg;
    logic              out_last_reg;
    logic [SW-1:0]     out_i_reg;
    logic [SW-1:0]     out_q_reg;
    logic [PROD_W-1:0] i_prod;
    logic [PROD_W-1:0] q_prod;
    logic [SW-1:0]     i_mag;
    logic [SW-1:0]     q_mag;
    logic [SW-1:0]     i_val;
    logic [SW-1:0]     q_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_step_reg  <= bfsk_pkg::MARK_STEP_RST;
            space_step_reg <= bfsk_pkg::SPACE_STEP_RST;
            spb_reg        <= bfsk_pkg::SPB_RST;
            amplitude_reg  <= bfsk_pkg::AMPLITUDE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bfsk_pkg::REG_MARK_STEP:  mark_step_reg  <= cfg_wdata;
                bfsk_pkg::REG_SPACE_STEP: space_step_reg <= cfg_wdata;
                bfsk_pkg::REG_SPB:        spb_reg        <= cfg_wdata[bfsk_pkg::SPB_W-1:0];
                bfsk_pkg::REG_AMPLITUDE:  amplitude_reg  <= cfg_wdata[bfsk_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pipe_en  = !out_valid_reg || m_tready;
        gen_fire = gen_active_reg && pipe_en;
        gen_done = gen_idle_reg || (gen_left_reg == bfsk_pkg::SPB_W'(1));
        s_tready = !gen_active_reg || (pipe_en && gen_done);
        accept   = s_tvalid && s_tready;

        if (spb_reg == '0)
            count = bfsk_pkg::SPB_W'(1);
        else if (spb_reg > bfsk_pkg::MAX_SAMPLES)
            count = bfsk_pkg::MAX_SAMPLES;
        else
            count = spb_reg;

        gen_active_next  = gen_active_reg;
        gen_idle_next    = gen_idle_reg;
        gen_mark_next    = gen_mark_reg;
        gen_left_next    = gen_left_reg;
        mark_phase_next  = mark_phase_reg;
        space_phase_next = space_phase_reg;

        if (gen_fire && !gen_idle_reg)
        begin
            gen_left_next    = gen_left_reg - bfsk_pkg::SPB_W'(1);
            mark_phase_next  = mark_phase_reg + mark_step_reg;
            space_phase_next = space_phase_reg + space_step_reg;
        end
        if (gen_fire && gen_done)
            gen_active_next = 1'b0;
        if (accept)
        begin
            gen_active_next = 1'b1;
            gen_idle_next   = s_tuser;
            gen_mark_next   = s_tdata[0];
            gen_left_next   = count;
        end

        sel_phase = gen_mark_reg ? mark_phase_reg : space_phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_active_reg  <= 1'b0;
            mark_phase_reg  <= '0;
            space_phase_reg <= '0;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            gen_active_reg  <= gen_active_next;
            mark_phase_reg  <= mark_phase_next;
            space_phase_reg <= space_phase_next;
            if (pipe_en)
            begin
                a_valid_reg   <= gen_active_reg;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gen_idle_reg <= gen_idle_next;
        gen_mark_reg <= gen_mark_next;
        gen_left_reg <= gen_left_next;
        if (pipe_en)
        begin
            a_zero_reg    <= gen_idle_reg;
            a_last_reg    <= gen_done;
            a_sin_idx_reg <= sel_phase[bfsk_pkg::PHASE_W-1 -: P];
            a_cos_idx_reg <= sel_phase[bfsk_pkg::PHASE_W-1 -: P] + P'(QUARTER);

            b_zero_reg    <= a_zero_reg;
            b_last_reg    <= a_last_reg;
            b_sin_mag_reg <= sin_mag;
            b_sin_neg_reg <= sin_neg;
            b_cos_mag_reg <= cos_mag;
            b_cos_neg_reg <= cos_neg;

            out_last_reg  <= b_last_reg;
            out_i_reg     <= i_val;
            out_q_reg     <= q_val;
        end
    end

    bfsk_sine_lut #(
        .TABLE_PHASE_BITS   (P),
        .TABLE_FRACTION_BITS(F)
    ) u_sin_lut (
        .idx(a_sin_idx_reg),
        .mag(sin_mag),
        .neg(sin_neg)
    );

    bfsk_sine_lut #(
        .TABLE_PHASE_BITS   (P),
        .TABLE_FRACTION_BITS(F)
    ) u_cos_lut (
        .idx(a_cos_idx_reg),
        .mag(cos_mag),
        .neg(cos_neg)
    );

    always_comb
    begin
        i_prod = PROD_W'(amplitude_reg) * PROD_W'(b_sin_mag_reg);
        q_prod = PROD_W'(amplitude_reg) * PROD_W'(b_cos_mag_reg);
        i_mag  = i_prod[F+SW-1:F];
        q_mag  = q_prod[F+SW-1:F];
        if (b_zero_reg)
        begin
            i_val = '0;
            q_val = '0;
        end
        else
        begin
            i_val = b_sin_neg_reg ? (SW'(0) - i_mag) : i_mag;
            q_val = b_cos_neg_reg ? (SW'(0) - q_mag) : q_mag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_q_reg, out_i_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> hw/rtl/bfsk_checker.sv
// ----------------------------------------------------------------------------
// bfsk_checker
// Port-level checks for the binary FSK I/Q modulator, bound to the top level.
// ----------------------------------------------------------------------------
module bfsk_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bfsk_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    localparam int SW = bfsk_pkg::SAMPLE_W;

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    // samples never reach the most negative code
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[SW-1:0] != 8'h80) && (m_tdata[2*SW-1:SW] != 8'h80))
        else $error("sample out of range");

    // samples of one bit leave without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a bit burst");

    // nothing valid during reset
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind binary_fsk_iq_modulator bfsk_checker u_bfsk_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

>>> test/binary_fsk_iq_modulator_tb.sv
// ----------------------------------------------------------------------------
// binary_fsk_iq_modulator_tb
// Self-checking bench for the binary FSK I/Q modulator. It keeps its own
// mark/space phase accumulators and a sine table built the same way as the
// block's table. Every accepted transaction is turned into the expected
// I/Q/last samples. Those are compared in order with the output stream while
// both stream sides idle at random.
// ----------------------------------------------------------------------------
module binary_fsk_iq_modulator_tb;

    localparam int TBL_BITS  = 10;
    localparam int FRAC_BITS = 15;
    localparam int TBL_SIZE  = 1 << TBL_BITS;
    localparam int QUARTER   = TBL_SIZE / 4;
    localparam int SW        = bfsk_pkg::SAMPLE_W;

    localparam logic KIND_BIT  = 1'b0;
    localparam logic KIND_IDLE = 1'b1;

    typedef struct {
        logic signed [SW-1:0] i_val;
        logic signed [SW-1:0] q_val;
        logic                 last;
    } iq_sample_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [bfsk_pkg::IN_DATA_W-1:0]      s_tdata = '0;
    logic                                s_tuser = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [bfsk_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                                m_tlast;
    logic                                cfg_we = 1'b0;
    logic [bfsk_pkg::CFG_ADDR_W-1:0]     cfg_addr = '0;
    logic [bfsk_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

    iq_sample_t      pending_samples[$];
    int              sine_lut[TBL_SIZE];
    int unsigned     mismatch_count = 0;
    bit              tx_quiet = 1'b0;
    bit              rx_quiet = 1'b0;

    logic [31:0]     mark_inc;
    logic [31:0]     space_inc;
    logic [6:0]      spb_reg;
    logic [6:0]      amp_reg;
    logic [31:0]     mark_acc;
    logic [31:0]     space_acc;

    binary_fsk_iq_modulator #(
        .TABLE_PHASE_BITS    (TBL_BITS),
        .TABLE_FRACTION_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Q30 Taylor sine on the folded quarter wave, rounded to FRAC_BITS
    function automatic int sine_at(input int unsigned k);
        int unsigned quad;
        int unsigned r;
        logic [63:0] ang;
        logic [63:0] term;
        logic [63:0] rounded;
        longint      acc;
        quad = (k >> (TBL_BITS - 2)) & 3;
        r    = k & (QUARTER - 1);
        if (quad[0])
            r = QUARTER - r;
        ang  = (64'(r) * 64'd1686629713) >> (TBL_BITS - 2);
        acc  = longint'(ang);
        term = ang;
        for (int n = 1; n <= 6; n++)
        begin
            term = ((((term * ang) >> 30) * ang) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > (longint'(1) << 30))
            acc = longint'(1) << 30;
        rounded = (64'(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return (quad >= 2) ? -int'(rounded) : int'(rounded);
    endfunction

    function automatic logic signed [SW-1:0] scale_by_amp(input int e);
        int unsigned mag;
        mag = (int'(amp_reg) * ((e < 0) ? -e : e)) >> FRAC_BITS;
        return (e < 0) ? SW'(-int'(mag)) : SW'(mag);
    endfunction

    function automatic void add_expected(input iq_sample_t s);
        pending_samples.insert(pending_samples.size(), s);
    endfunction

    task automatic modulate_item(input logic kind, input logic bit_val);
        iq_sample_t  s;
        int unsigned count;
        int unsigned idx;
        logic [31:0] ph;
        if (kind == KIND_IDLE)
        begin
            s.i_val = '0;
            s.q_val = '0;
            s.last  = 1'b1;
            add_expected(s);
            return;
        end
        count = (spb_reg == 0) ? 1 :
                (spb_reg > bfsk_pkg::MAX_SAMPLES) ? bfsk_pkg::MAX_SAMPLES : spb_reg;
        for (int unsigned k = 0; k < count; k++)
        begin
            ph      = bit_val ? mark_acc : space_acc;
            idx     = ph >> (32 - TBL_BITS);
            s.i_val = scale_by_amp(sine_lut[idx]);
            s.q_val = scale_by_amp(sine_lut[(idx + QUARTER) % TBL_SIZE]);
            s.last  = (k + 1 == count);
            add_expected(s);
            mark_acc  = mark_acc + mark_inc;
            space_acc = space_acc + space_inc;
        end
    endtask

    task automatic send_item(input logic kind, input logic bit_val);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(bfsk_pkg::IN_DATA_W-1){1'b0}}, bit_val};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        modulate_item(kind, bit_val);
    endtask

    task automatic write_reg(input logic [bfsk_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [bfsk_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            bfsk_pkg::REG_MARK_STEP:  mark_inc  = val;
            bfsk_pkg::REG_SPACE_STEP: space_inc = val;
            bfsk_pkg::REG_SPB:        spb_reg   = val[6:0];
            bfsk_pkg::REG_AMPLITUDE:  amp_reg   = val[6:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_default_setting();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        send_item(KIND_BIT, 1'b1);
        send_item(KIND_BIT, 1'b0);
        send_item(KIND_IDLE, 1'b1);
        send_item(KIND_IDLE, 1'b0);
        wait_drained();
    endtask

    task automatic test_sample_count_limits();
        logic [31:0] counts[6];
        counts = '{32'd0, 32'd1, 32'd64, 32'd65, 32'd127, 32'hFFFF_FF83};
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        foreach (counts[n])
        begin
            write_reg(bfsk_pkg::REG_SPB, counts[n]);
            send_item(KIND_BIT, n[0]);
            wait_drained();
        end
    endtask

    task automatic test_amplitude_and_steps();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        write_reg(bfsk_pkg::REG_AMPLITUDE, 32'd0);
        write_reg(bfsk_pkg::REG_SPB, 32'd4);
        send_item(KIND_BIT, 1'b1);
        send_item(KIND_BIT, 1'b0);
        wait_drained();
        // quarter-cycle mark step lands exactly on the quadrant boundaries
        write_reg(bfsk_pkg::REG_AMPLITUDE, 32'd127);
        write_reg(bfsk_pkg::REG_MARK_STEP, 32'h4000_0000);
        write_reg(bfsk_pkg::REG_SPACE_STEP, 32'hFFFF_FFFF);
        write_reg(bfsk_pkg::REG_SPB, 32'd8);
        send_item(KIND_BIT, 1'b1);
        send_item(KIND_BIT, 1'b0);
        send_item(KIND_BIT, 1'b1);
        send_item(KIND_IDLE, 1'b0);
        wait_drained();
        write_reg(bfsk_pkg::REG_MARK_STEP, 32'd0);
        write_reg(bfsk_pkg::REG_SPACE_STEP, 32'd0);
        send_item(KIND_BIT, 1'b1);
        send_item(KIND_BIT, 1'b0);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        write_reg(bfsk_pkg::REG_SPB, 32'd1);
        write_reg(bfsk_pkg::REG_MARK_STEP, $urandom);
        write_reg(bfsk_pkg::REG_SPACE_STEP, $urandom);
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        send_item(KIND_BIT, 1'b1);
        send_item(KIND_IDLE, 1'b1);
        send_item(KIND_BIT, 1'b0);
        rx_quiet = 1'b1;
        send_item(KIND_IDLE, 1'b0);
        send_item(KIND_BIT, 1'b0);
        send_item(KIND_BIT, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_stream();
        logic [31:0] spb_val;
        logic [31:0] amp_val;
        for (int p = 0; p < 7; p++)
        begin
            wait_drained();
            case ($urandom_range(7))
                0:       spb_val = 32'd0;
                1:       spb_val = $urandom_range(9, 127);
                default: spb_val = $urandom_range(1, 8);
            endcase
            if (p == 3)
                spb_val = 32'd64;
            case ($urandom_range(3))
                0:       amp_val = 32'd127;
                1:       amp_val = {$urandom} & 32'hFFFF_FF80;
                default: amp_val = $urandom;
            endcase
            write_reg(bfsk_pkg::REG_SPB, spb_val);
            write_reg(bfsk_pkg::REG_AMPLITUDE, amp_val);
            write_reg(bfsk_pkg::REG_MARK_STEP,
                      $urandom_range(1) ? $urandom : $urandom_range(0, 32'h0800_0000));
            write_reg(bfsk_pkg::REG_SPACE_STEP,
                      $urandom_range(1) ? $urandom : $urandom_range(0, 32'h0800_0000));
            tx_quiet = ($urandom_range(3) == 0);
            rx_quiet = ($urandom_range(3) == 0);
            for (int n = 0; n < 20; n++)
            begin
                if (p == 2 && n == 10)
                    wait_drained();
                send_item(($urandom_range(3) == 0) ? KIND_IDLE : KIND_BIT, $urandom_range(1));
            end
        end
        wait_drained();
    endtask

    // output sink: random stalls, in-order compare
    initial
    begin : sample_sink
        int unsigned          hold;
        iq_sample_t           want;
        logic signed [SW-1:0] got_i;
        logic signed [SW-1:0] got_q;
        wait (rst_n === 1'b1);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid)
            begin
                got_i = m_tdata[SW-1:0];
                got_q = m_tdata[2*SW-1:SW];
                if (pending_samples.size() == 0)
                begin
                    mismatch_count++;
                    $error("unexpected transaction: i_sample=%0d q_sample=%0d last=%0b",
                           got_i, got_q, m_tlast);
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (got_i !== want.i_val)
                    begin
                        mismatch_count++;
                        $error("i_sample: expected %0d, got %0d", want.i_val, got_i);
                    end
                    if (got_q !== want.q_val)
                    begin
                        mismatch_count++;
                        $error("q_sample: expected %0d, got %0d", want.q_val, got_q);
                    end
                    if (m_tlast !== want.last)
                    begin
                        mismatch_count++;
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                    end
                end
                hold = rx_quiet ? 0 : $urandom_range(15);
                if (hold != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (hold) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        for (int k = 0; k < TBL_SIZE; k++)
            sine_lut[k] = sine_at(k);
        mark_inc  = bfsk_pkg::MARK_STEP_RST;
        space_inc = bfsk_pkg::SPACE_STEP_RST;
        spb_reg   = bfsk_pkg::SPB_RST;
        amp_reg   = bfsk_pkg::AMPLITUDE_RST;
        mark_acc  = '0;
        space_acc = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_setting();
        test_sample_count_limits();
        test_amplitude_and_steps();
        test_back_to_back();
        test_random_stream();

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
